// ===== src/assert_macros.svh =====
// Assertion macros used by the launcher fire sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked at every rising clock edge while out of reset.
`define LFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfs assertion failed");

// Condition that must never be true while out of reset.
`define LFS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lfs forbidden condition seen");

`else

`define LFS_ASSERT(lbl, clk, rst_n, prop)
`define LFS_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/lfs_pkg.sv =====
// Package with the types and codes of the launcher fire sequencer.
package lfs_pkg;

    localparam int TimeW  = 32;
    localparam int SpeedW = 16;
    localparam int CfgW   = 16;
    localparam int PhaseW = 3;

    localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
    localparam logic [PhaseW-1:0] PH_SPINUP   = 3'd1;
    localparam logic [PhaseW-1:0] PH_READY    = 3'd2;
    localparam logic [PhaseW-1:0] PH_FIRE     = 3'd3;
    localparam logic [PhaseW-1:0] PH_COOLDOWN = 3'd4;
    localparam logic [PhaseW-1:0] PH_FAULT    = 3'd5;
    localparam logic [PhaseW-1:0] PH_ESTOP    = 3'd6;

    localparam logic CFG_RELOAD_DELAY    = 1'b0;
    localparam logic CFG_SPEED_TOLERANCE = 1'b1;

    localparam logic [CfgW-1:0] RELOAD_DELAY_RST    = 16'd1000;
    localparam logic [CfgW-1:0] SPEED_TOLERANCE_RST = 16'd80;

    typedef struct packed {
        logic [TimeW-1:0]         now_ms;
        logic                     emergency_stop;
        logic                     fault_active;
        logic signed [SpeedW-1:0] base_speed;
        logic                     ball_loaded;
        logic                     fire_request;
        logic signed [SpeedW-1:0] actual_rpm_1;
        logic signed [SpeedW-1:0] target_rpm_1;
        logic signed [SpeedW-1:0] actual_rpm_2;
        logic signed [SpeedW-1:0] target_rpm_2;
        logic signed [SpeedW-1:0] actual_rpm_3;
        logic signed [SpeedW-1:0] target_rpm_3;
    } item_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic              trigger_launch;
        logic              fire_request_consumed;
    } result_t;

endpackage

// ===== src/lfs_wheel_check.sv =====
// Tolerance check of one wheel speed against its target.
module lfs_wheel_check (
    input  logic signed [lfs_pkg::SpeedW-1:0] actual,
    input  logic signed [lfs_pkg::SpeedW-1:0] target,
    input  logic        [lfs_pkg::CfgW-1:0]   tolerance,
    output logic                              in_tol
);

    logic signed [lfs_pkg::SpeedW:0] diff;
    logic        [lfs_pkg::SpeedW:0] mag;

    // The difference needs one extra bit so it never wraps.
    assign diff = {actual[lfs_pkg::SpeedW-1], actual} - {target[lfs_pkg::SpeedW-1], target};
    assign mag  = diff[lfs_pkg::SpeedW] ? (~diff + 1'b1) : diff;
    assign in_tol = mag <= {1'b0, tolerance};

endmodule

// ===== src/lfs_phase_fsm.sv =====
// Launch phase state machine with its entry timestamp.
`include "assert_macros.svh"

module lfs_phase_fsm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  lfs_pkg::item_t               item,
    input  logic [lfs_pkg::CfgW-1:0]     reload_delay,
    input  logic [lfs_pkg::CfgW-1:0]     tolerance,
    output lfs_pkg::result_t             result
);

    logic [lfs_pkg::PhaseW-1:0] phase_reg;
    logic [lfs_pkg::PhaseW-1:0] phase_next;
    logic [lfs_pkg::TimeW-1:0]  entry_reg;
    logic [lfs_pkg::TimeW-1:0]  entry_next;
    logic [lfs_pkg::TimeW-1:0]  elapsed;
    logic                       ok_1;
    logic                       ok_2;
    logic                       ok_3;
    logic                       speed_on;
    logic                       trig;
    logic                       consumed;
    logic                       in_estop;
    logic                       in_hold;

    lfs_wheel_check u_wheel_1 (
        .actual    (item.actual_rpm_1),
        .target    (item.target_rpm_1),
        .tolerance (tolerance),
        .in_tol    (ok_1)
    );

    lfs_wheel_check u_wheel_2 (
        .actual    (item.actual_rpm_2),
        .target    (item.target_rpm_2),
        .tolerance (tolerance),
        .in_tol    (ok_2)
    );

    lfs_wheel_check u_wheel_3 (
        .actual    (item.actual_rpm_3),
        .target    (item.target_rpm_3),
        .tolerance (tolerance),
        .in_tol    (ok_3)
    );

    assign speed_on = !item.base_speed[lfs_pkg::SpeedW-1] && (item.base_speed != '0);
    assign elapsed  = item.now_ms - entry_reg;

    always_comb
    begin
        phase_next = phase_reg;
        entry_next = entry_reg;
        trig       = 1'b0;
        consumed   = 1'b0;
        if (item.emergency_stop)
        begin
            phase_next = lfs_pkg::PH_ESTOP;
        end
        else if (item.fault_active)
        begin
            phase_next = lfs_pkg::PH_FAULT;
        end
        else
        begin
            unique case (phase_reg)
                lfs_pkg::PH_IDLE:
                begin
                    if (speed_on)
                    begin
                        phase_next = lfs_pkg::PH_SPINUP;
                        entry_next = item.now_ms;
                    end
                end
                lfs_pkg::PH_SPINUP:
                begin
                    if (item.ball_loaded && ok_1 && ok_2 && ok_3)
                    begin
                        phase_next = lfs_pkg::PH_READY;
                        entry_next = item.now_ms;
                    end
                end
                lfs_pkg::PH_READY:
                begin
                    if (!item.ball_loaded)
                    begin
                        phase_next = lfs_pkg::PH_SPINUP;
                        entry_next = item.now_ms;
                    end
                    else if (item.fire_request)
                    begin
                        trig       = 1'b1;
                        phase_next = lfs_pkg::PH_FIRE;
                        entry_next = item.now_ms;
                    end
                end
                lfs_pkg::PH_FIRE:
                begin
                    consumed   = 1'b1;
                    phase_next = lfs_pkg::PH_COOLDOWN;
                    entry_next = item.now_ms;
                end
                lfs_pkg::PH_COOLDOWN:
                begin
                    if (elapsed >= {{(lfs_pkg::TimeW-lfs_pkg::CfgW){1'b0}}, reload_delay})
                    begin
                        phase_next = speed_on ? lfs_pkg::PH_SPINUP : lfs_pkg::PH_IDLE;
                        entry_next = item.now_ms;
                    end
                end
                default:
                begin
                    // Fault and stop hold until reset.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lfs_pkg::PH_IDLE;
            entry_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            entry_reg <= entry_next;
        end
    end

    assign result.phase                 = phase_next;
    assign result.trigger_launch        = trig;
    assign result.fire_request_consumed = consumed;

    assign in_estop = phase_reg == lfs_pkg::PH_ESTOP;
    assign in_hold  = in_estop || (phase_reg == lfs_pkg::PH_FAULT);

    `LFS_ASSERT(a_trig_from_ready, clk, rst_n, trig |-> (phase_reg == lfs_pkg::PH_READY))
    `LFS_ASSERT(a_fire_to_cool, clk, rst_n, (advance && consumed) |=> (phase_reg == lfs_pkg::PH_COOLDOWN))
    `LFS_ASSERT(a_estop_holds, clk, rst_n, in_estop |=> in_hold)
    `LFS_ASSERT(a_entry_stable, clk, rst_n, !advance |=> $stable(entry_reg))

endmodule

// ===== src/launcher_fire_sequencer_top.sv =====
// Top level of the launcher fire sequencer: handshake stages and configuration.
// A word accepted sits in the input register, moves into the result register and is
// handed out from there. Throughput: one word per cycle while results are taken, set
// by the phase update between the two registers. Reset (rst_n, asynchronous, active
// low) empties both stages, puts the phase in idle with a zero entry time, and loads
// the default delay and tolerance.
module launcher_fire_sequencer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [lfs_pkg::CfgW-1:0]           cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lfs_pkg::TimeW-1:0]          now_ms,
    input  logic                               emergency_stop,
    input  logic                               fault_active,
    input  logic signed [lfs_pkg::SpeedW-1:0]  base_speed,
    input  logic                               ball_loaded,
    input  logic                               fire_request,
    input  logic signed [lfs_pkg::SpeedW-1:0]  actual_rpm_1,
    input  logic signed [lfs_pkg::SpeedW-1:0]  target_rpm_1,
    input  logic signed [lfs_pkg::SpeedW-1:0]  actual_rpm_2,
    input  logic signed [lfs_pkg::SpeedW-1:0]  target_rpm_2,
    input  logic signed [lfs_pkg::SpeedW-1:0]  actual_rpm_3,
    input  logic signed [lfs_pkg::SpeedW-1:0]  target_rpm_3,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lfs_pkg::PhaseW-1:0]         phase,
    output logic                               trigger_launch,
    output logic                               fire_request_consumed
);

    // Configuration registers, written directly by the plain write port.
    logic [lfs_pkg::CfgW-1:0] reload_delay_reg;
    logic [lfs_pkg::CfgW-1:0] tolerance_reg;

    // Input stage holds one accepted word; result stage holds one finished word.
    logic                     in_valid_reg;
    lfs_pkg::item_t           item_reg;
    logic                     out_valid_reg;
    lfs_pkg::result_t         result_reg;
    lfs_pkg::result_t         result_next;
    logic                     out_free;
    logic                     advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_delay_reg <= lfs_pkg::RELOAD_DELAY_RST;
            tolerance_reg    <= lfs_pkg::SPEED_TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfs_pkg::CFG_RELOAD_DELAY:    reload_delay_reg <= cfg_wdata;
                lfs_pkg::CFG_SPEED_TOLERANCE: tolerance_reg    <= cfg_wdata;
                default:                      reload_delay_reg <= reload_delay_reg;
            endcase
        end
    end

    // The result stage can take a new word when empty or when its word leaves.
    // The input word advances into it, updating the phase state in the same edge,
    // so the next word sees the phase left by this one.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.now_ms         <= now_ms;
            item_reg.emergency_stop <= emergency_stop;
            item_reg.fault_active   <= fault_active;
            item_reg.base_speed     <= base_speed;
            item_reg.ball_loaded    <= ball_loaded;
            item_reg.fire_request   <= fire_request;
            item_reg.actual_rpm_1   <= actual_rpm_1;
            item_reg.target_rpm_1   <= target_rpm_1;
            item_reg.actual_rpm_2   <= actual_rpm_2;
            item_reg.target_rpm_2   <= target_rpm_2;
            item_reg.actual_rpm_3   <= actual_rpm_3;
            item_reg.target_rpm_3   <= target_rpm_3;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    lfs_phase_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (item_reg),
        .reload_delay (reload_delay_reg),
        .tolerance    (tolerance_reg),
        .result       (result_next)
    );

    assign out_valid             = out_valid_reg;
    assign phase                 = result_reg.phase;
    assign trigger_launch        = result_reg.trigger_launch;
    assign fire_request_consumed = result_reg.fire_request_consumed;

endmodule

// ===== verif/launcher_fire_sequencer_top_tb.sv =====
// Self-checking testbench for the launcher fire sequencer top level.
module launcher_fire_sequencer_top_tb;
    import lfs_pkg::*;

    // Tracks the launch sequence the same way the block should, keeps the
    // expected result of every accepted word in order, and compares each
    // word the block hands back against the oldest expectation.
    class launch_scoreboard;
        logic [CfgW-1:0]   reload_delay;
        logic [CfgW-1:0]   speed_tol;
        logic [PhaseW-1:0] seq_phase;
        logic [TimeW-1:0]  entry_ms;
        result_t           expected_q[$];
        int unsigned       errors;
        int unsigned       words_in;
        int unsigned       results_seen;
        int unsigned       launches;
        int unsigned       phase_hits[8];

        function new();
            reload_delay = RELOAD_DELAY_RST;
            speed_tol    = SPEED_TOLERANCE_RST;
            seq_phase    = PH_IDLE;
            entry_ms     = '0;
            errors       = 0;
            words_in     = 0;
            results_seen = 0;
            launches     = 0;
            foreach (phase_hits[i])
                phase_hits[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [CfgW-1:0] value);
            if (idx == CFG_RELOAD_DELAY)
                reload_delay = value;
            else
                speed_tol = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The speed error is taken at full width, so a span of 65535 is legal.
        function bit wheel_ok(logic signed [SpeedW-1:0] act, logic signed [SpeedW-1:0] tgt);
            int err;
            err = int'(act) - int'(tgt);
            if (err < 0)
                err = -err;
            return err <= int'(speed_tol);
        endfunction

        function void note_word(item_t w);
            result_t r;
            bit      spin_req;
            bit      wheels_ok;
            spin_req  = $signed(w.base_speed) > 0;
            wheels_ok = wheel_ok(w.actual_rpm_1, w.target_rpm_1) &&
                        wheel_ok(w.actual_rpm_2, w.target_rpm_2) &&
                        wheel_ok(w.actual_rpm_3, w.target_rpm_3);
            r.trigger_launch        = 1'b0;
            r.fire_request_consumed = 1'b0;
            // Stop outranks fault; neither touches the entry timestamp.
            if (w.emergency_stop)
                seq_phase = PH_ESTOP;
            else if (w.fault_active)
                seq_phase = PH_FAULT;
            else begin
                case (seq_phase)
                    PH_IDLE:
                        if (spin_req)
                        begin
                            seq_phase = PH_SPINUP;
                            entry_ms  = w.now_ms;
                        end
                    PH_SPINUP:
                        if (w.ball_loaded && wheels_ok)
                        begin
                            seq_phase = PH_READY;
                            entry_ms  = w.now_ms;
                        end
                    PH_READY:
                        if (!w.ball_loaded)
                        begin
                            seq_phase = PH_SPINUP;
                            entry_ms  = w.now_ms;
                        end
                        else if (w.fire_request)
                        begin
                            r.trigger_launch = 1'b1;
                            seq_phase        = PH_FIRE;
                            entry_ms         = w.now_ms;
                        end
                    PH_FIRE:
                    begin
                        r.fire_request_consumed = 1'b1;
                        seq_phase               = PH_COOLDOWN;
                        entry_ms                = w.now_ms;
                    end
                    PH_COOLDOWN:
                        // Elapsed time wraps modulo 2^32 with the clock.
                        if (TimeW'(w.now_ms - entry_ms) >= TimeW'(reload_delay))
                        begin
                            seq_phase = spin_req ? PH_SPINUP : PH_IDLE;
                            entry_ms  = w.now_ms;
                        end
                    default:
                        ;
                endcase
            end
            r.phase = seq_phase;
            phase_hits[seq_phase]++;
            if (r.trigger_launch)
                launches++;
            words_in++;
            expected_q.push_back(r);
        endfunction

        // Only the first stretch of mismatches is printed so that a badly broken
        // block cannot flood the log; every one of them is still counted.
        task report(string msg);
            if (errors < 60)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic [PhaseW-1:0] ph, logic trig, logic used);
            result_t exp_r;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result phase=%0d with no word outstanding", ph));
                return;
            end
            exp_r = expected_q.pop_front();
            if (ph !== exp_r.phase)
                report($sformatf("result %0d: phase %0d, expected %0d",
                                 results_seen, ph, exp_r.phase));
            if (trig !== exp_r.trigger_launch)
                report($sformatf("result %0d: trigger_launch %b, expected %b",
                                 results_seen, trig, exp_r.trigger_launch));
            if (used !== exp_r.fire_request_consumed)
                report($sformatf("result %0d: fire_request_consumed %b, expected %b",
                                 results_seen, used, exp_r.fire_request_consumed));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CfgW-1:0]   cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    item_t             word_q;
    logic              out_valid;
    logic              out_ready;
    logic [PhaseW-1:0] phase;
    logic              trigger_launch;
    logic              fire_request_consumed;

    launch_scoreboard  sb = new();

    // Stimulus bookkeeping: the running millisecond clock, the register values
    // the random words are shaped for, and the sender's burst counter.
    logic [TimeW-1:0]  clock_ms;
    int unsigned       cur_delay;
    int unsigned       cur_tol;
    int unsigned       burst_left;
    int unsigned       settings_run;
    bit                stall_req;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    launcher_fire_sequencer_top u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .now_ms                (word_q.now_ms),
        .emergency_stop        (word_q.emergency_stop),
        .fault_active          (word_q.fault_active),
        .base_speed            (word_q.base_speed),
        .ball_loaded           (word_q.ball_loaded),
        .fire_request          (word_q.fire_request),
        .actual_rpm_1          (word_q.actual_rpm_1),
        .target_rpm_1          (word_q.target_rpm_1),
        .actual_rpm_2          (word_q.actual_rpm_2),
        .target_rpm_2          (word_q.target_rpm_2),
        .actual_rpm_3          (word_q.actual_rpm_3),
        .target_rpm_3          (word_q.target_rpm_3),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .phase                 (phase),
        .trigger_launch        (trigger_launch),
        .fire_request_consumed (fire_request_consumed)
    );

    // Both handshakes are sampled at the rising edge, where every input still
    // holds the value driven one step earlier. The input side is noted first,
    // although a word passes both registers of the block before it comes back, so the order cannot matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(word_q);
            if (out_valid && out_ready)
                sb.check_word(phase, trigger_launch, fire_request_consumed);
        end
    end

    // The receiver picks a random mood at regular ticks: always ready, a coin
    // toss, mostly ready, or ready one cycle in three. On request from the
    // stimulus it refuses everything until its hold count, kept here, runs out,
    // which backs the block up until it refuses words as well.
    initial
    begin
        int unsigned hold_left;
        int unsigned tick;
        int unsigned mood;
        hold_left = 0;
        tick      = 0;
        mood      = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = 300;
            end
            if (tick % 50 == 0)
                mood = $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (mood)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= $urandom_range(0, 9) != 0;
                    default: out_ready <= tick % 3 == 0;
                endcase
        end
    end

    // Offer one word and hold it until the block takes it. The task returns in
    // the step of the accepting edge, so the caller may put the next word up
    // right away without lowering valid in between.
    task automatic send_word(item_t w);
        word_q   <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_for(int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Bursty sender: a run of back-to-back words, then a gap, which is often
    // zero so that long stretches flow without any idling.
    task automatic send_paced(item_t w);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
        end
        burst_left--;
        send_word(w);
    endtask

    // Stop offering words and wait until every result is back, plus a few
    // more cycles so that the block is truly empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the trailing edge keeps the write enable from being
    // raised and lowered in the same step when writes follow each other.
    task automatic write_reg(logic idx, logic [CfgW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(int unsigned delay, int unsigned tol);
        write_reg(CFG_RELOAD_DELAY, CfgW'(delay));
        write_reg(CFG_SPEED_TOLERANCE, CfgW'(tol));
        cur_delay = delay;
        cur_tol   = tol;
        settings_run++;
    endtask

    // A word with the wheels at rest and on target and no stop or fault.
    function automatic item_t plain_word(logic [TimeW-1:0] now, logic signed [SpeedW-1:0] base,
                                         bit ball, bit fire);
        item_t w;
        w                = '0;
        w.now_ms         = now;
        w.base_speed     = base;
        w.ball_loaded    = ball;
        w.fire_request   = fire;
        return w;
    endfunction

    // Mostly produces a wheel within tolerance, with a good share landing on
    // the boundary or one past it, plus some far-off and full-span pairs.
    function automatic void wheel_pair(int unsigned tol, output logic signed [SpeedW-1:0] act,
                                       output logic signed [SpeedW-1:0] tgt);
        int          t;
        int          d;
        int          a;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        t    = int'($urandom_range(0, 65535)) - 32768;
        if (roll < 5)
        begin
            act = roll[0] ? 16'sh7FFF : 16'sh8000;
            tgt = roll[0] ? 16'sh8000 : 16'sh7FFF;
            return;
        end
        if (roll < 15)
        begin
            act = SpeedW'($urandom);
            tgt = SpeedW'(t);
            return;
        end
        if (roll < 30)
            d = int'(tol) + int'(roll % 2);
        else
            d = int'($urandom_range(0, tol));
        if ($urandom_range(0, 1))
            d = -d;
        a = t + d;
        if (a > 32767 || a < -32768)
            a = t - d;
        if (a > 32767 || a < -32768)
            a = t;
        act = SpeedW'(a);
        tgt = SpeedW'(t);
    endfunction

    // Random word shaped to walk the whole launch cycle: time mostly moves
    // forward in steps scaled to the reload delay, speed is mostly requested,
    // the ball is mostly in place and the wheels mostly on speed. A tenth of
    // the words are plain noise and time jumps now and then.
    function automatic item_t make_word();
        item_t       w;
        int unsigned pick;
        w    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            w.now_ms       = $urandom;
            w.base_speed   = SpeedW'($urandom);
            w.ball_loaded  = $urandom_range(0, 1);
            w.fire_request = $urandom_range(0, 1);
            w.actual_rpm_1 = SpeedW'($urandom);
            w.target_rpm_1 = SpeedW'($urandom);
            w.actual_rpm_2 = SpeedW'($urandom);
            w.target_rpm_2 = SpeedW'($urandom);
            w.actual_rpm_3 = SpeedW'($urandom);
            w.target_rpm_3 = SpeedW'($urandom);
            clock_ms       = w.now_ms;
            return w;
        end
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, cur_delay / 4 + 3);
        w.now_ms = clock_ms;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            w.base_speed = SpeedW'($urandom_range(1, 32767));
        else if (pick == 7)
            w.base_speed = '0;
        else if (pick == 8)
            w.base_speed = SpeedW'(-int'($urandom_range(1, 32768)));
        else
            w.base_speed = SpeedW'($urandom);
        w.ball_loaded  = $urandom_range(0, 99) < 85;
        w.fire_request = $urandom_range(0, 99) < 35;
        wheel_pair(cur_tol, w.actual_rpm_1, w.target_rpm_1);
        wheel_pair(cur_tol, w.actual_rpm_2, w.target_rpm_2);
        wheel_pair(cur_tol, w.actual_rpm_3, w.target_rpm_3);
        return w;
    endfunction

    // Hand-picked walk through the sequence at the reset settings (reload
    // delay 1000 ms, tolerance 80 rpm): speed commands at zero and at both
    // extremes, wheel errors exactly on and just past the tolerance, a full
    // wheel span, the ball vanishing in ready even with a fire request
    // pending, a cooldown that straddles the wrap of the millisecond clock
    // and ends exactly on the delay, and exits from cooldown to both idle and
    // spin-up.
    task automatic run_directed();
        item_t w;
        send_word(plain_word(32'd0, 16'sd0, 1'b0, 1'b0));
        send_word(plain_word(32'd1, 16'sh8000, 1'b1, 1'b1));
        send_word(plain_word(32'd5, 16'sh7FFF, 1'b0, 1'b0));
        w = plain_word(32'd6, 16'sd1, 1'b1, 1'b0);
        w.actual_rpm_1 = 16'sd100;
        w.target_rpm_1 = 16'sd20;
        w.actual_rpm_2 = -16'sd50;
        w.target_rpm_2 = 16'sd31;
        send_word(w);
        w = plain_word(32'd7, 16'sd1, 1'b1, 1'b0);
        w.actual_rpm_3 = 16'sh7FFF;
        w.target_rpm_3 = 16'sh8000;
        send_word(w);
        send_word(plain_word(32'd8, 16'sd1, 1'b0, 1'b1));
        w = plain_word(32'd9, 16'sd1, 1'b1, 1'b0);
        w.actual_rpm_1 = -16'sd100;
        w.target_rpm_1 = -16'sd20;
        w.actual_rpm_2 = 16'sh8000;
        w.target_rpm_2 = 16'sh8050;
        send_word(w);
        send_word(plain_word(32'd10, 16'sd1, 1'b1, 1'b0));
        send_word(plain_word(32'd11, 16'sd1, 1'b0, 1'b1));
        send_word(plain_word(32'd12, 16'sd1, 1'b1, 1'b0));
        send_word(plain_word(32'd13, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'hFFFF_FFFF, 16'sd0, 1'b0, 1'b1));
        send_word(plain_word(32'd998, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd999, 16'sd0, 1'b1, 1'b0));
        send_word(plain_word(32'd1000, 16'sd0, 1'b1, 1'b1));
        send_word(plain_word(32'd1001, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd1002, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd1003, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd1004, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd1004, 16'sd1, 1'b1, 1'b1));
        send_word(plain_word(32'd2004, 16'sd1, 1'b1, 1'b1));
        clock_ms = 32'd2004;
    endtask

    // Stop and fault latch until reset, and reset happens only once, so they
    // are exercised last: fault, fault held, stop taking over, fault taking
    // back over, both at once, then random flags.
    task automatic run_latching();
        item_t w;
        w = make_word();
        w.fault_active = 1'b1;
        send_paced(w);
        repeat (3) send_paced(make_word());
        w = make_word();
        w.emergency_stop = 1'b1;
        send_paced(w);
        w = make_word();
        w.fault_active = 1'b1;
        send_paced(w);
        w = make_word();
        w.emergency_stop = 1'b1;
        w.fault_active   = 1'b1;
        send_paced(w);
        repeat (8)
        begin
            w = make_word();
            w.emergency_stop = $urandom_range(0, 1);
            w.fault_active   = $urandom_range(0, 1);
            send_paced(w);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_RELOAD_DELAY;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        word_q       <= '0;
        clock_ms     = '0;
        cur_delay    = RELOAD_DELAY_RST;
        cur_tol      = SPEED_TOLERANCE_RST;
        burst_left   = 0;
        settings_run = 1;
        stall_req    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        // Six random phases of 125 words. The first two pin the registers to
        // their extremes; one phase starts the clock just short of the wrap.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apply_setting(0, 65535);
                1: apply_setting(65535, 0);
                2: apply_setting(1000, 80);
                3: apply_setting($urandom_range(1, 3000), $urandom_range(0, 300));
                4: apply_setting(37, 1);
                default: apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            if (ph == 3)
                clock_ms = 32'hFFFF_0000;
            for (int n = 0; n < 125; n++)
            begin
                // Midway through one phase the receiver goes quiet for a long
                // stretch while words keep coming.
                if (ph == 2 && n == 40)
                    stall_req = 1'b1;
                send_paced(make_word());
            end
            settle();
        end

        run_latching();
        settle();
        repeat (6) @(posedge clk);

        $display("Run covered %0d words and %0d results over %0d register settings, %0d launches.",
                 sb.words_in, sb.results_seen, settings_run, sb.launches);
        $display("Phase visits: idle %0d, spinup %0d, ready %0d, fire %0d, cooldown %0d, fault %0d, estop %0d.",
                 sb.phase_hits[PH_IDLE], sb.phase_hits[PH_SPINUP], sb.phase_hits[PH_READY],
                 sb.phase_hits[PH_FIRE], sb.phase_hits[PH_COOLDOWN], sb.phase_hits[PH_FAULT],
                 sb.phase_hits[PH_ESTOP]);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // A clean run ends well before this timeout, even with the slowest
    // receiver mood and the long stall.
    initial
    begin
        #200000;
        $display("Timeout with %0d results still outstanding.", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
